>>> rtl/max_xor_subarray_trie_defines.svh
// Assertion macros used by the checker file.
`ifndef MAX_XOR_SUBARRAY_TRIE_DEFINES_SVH
`define MAX_XOR_SUBARRAY_TRIE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define MXT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define MXT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/mxt_pkg.sv
// ----------------------------------------------------------------------------
// mxt_pkg
// Constants and types shared by the maximum-XOR trie block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mxt_pkg;
	localparam int VALUE_BITS = 31;
	localparam int NODE_COUNT = 32768;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int LVL_BITS   = $clog2(VALUE_BITS);
	localparam int CNT_BITS   = NODE_BITS + 8;
	localparam int ENT_BITS   = 2 * NODE_BITS;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CLR   = 8'b0000_0010,
		S_QRD   = 8'b0000_0100,
		S_QEV   = 8'b0000_1000,
		S_IRD   = 8'b0001_0000,
		S_IEV   = 8'b0010_0000,
		S_LINK  = 8'b0100_0000,
		S_ALLOC = 8'b1000_0000
	} state_t;
endpackage

>>> rtl/mxt_ram.sv
// ----------------------------------------------------------------------------
// mxt_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mxt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/mxt_cell.sv
// ----------------------------------------------------------------------------
// mxt_cell
// One bit of the key rotator: loads in parallel or takes its neighbour's bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mxt_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic load_bit,
	input  logic rot,
	input  logic shift_in,
	output logic bit_q
);
	// hold, load or advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (load) begin
			bit_q <= load_bit;
		end else if (rot) begin
			bit_q <= shift_in;
		end
	end
endmodule

>>> rtl/max_xor_subarray_trie.sv
// ----------------------------------------------------------------------------
// max_xor_subarray_trie
// Running maximum subarray XOR using a binary trie of prefix XORs.
// ----------------------------------------------------------------------------
// Usage: a word (value, start_new) is taken at a clock edge where start is
// high and busy is low. start_new clears the trie, prefix, best and overflow
// before the value is used. The result word (best_xor, overflow) shows for
// exactly one cycle with done high; the receiver cannot stall it.
// Walks: the query walk reads the node RAM, then decides, at each level it
// visits; the insert walk reads and decides at each level it follows, then
// does one link write and one write per new node. busy stays high for the
// whole item. After reset the block writes the root and the zero prefix
// path, with busy high. Once the node RAM is full, inserts stop and overflow
// stays set until start_new.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module max_xor_subarray_trie (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mxt_pkg::VALUE_BITS-1:0] value,
	input  logic                           start_new,
	output logic                           done,
	output logic [mxt_pkg::VALUE_BITS-1:0] best_xor,
	output logic                           overflow
);
	import mxt_pkg::*;

	state_t                state_q;
	logic [VALUE_BITS-1:0] prefix_q, best_q, gain_q, gain_nx, prefix_nx;
	logic                  full_q, init_q, item_q, done_q;
	logic [NODE_BITS-1:0]  cur_q, other, same, nx;
	logic [NODE_BITS:0]    nf_q;
	logic [NODE_BITS-1:0]  nf_lo, nf_inc;
	logic [LVL_BITS-1:0]   lvl_q;
	logic [ENT_BITS-1:0]   ent_q, rdata, wdata;
	logic [NODE_BITS-1:0]  waddr;
	logic                  we;
	logic [VALUE_BITS-1:0] chain, chain_in;
	logic                  ch_load, ch_rot, key_bit, accept, q_end, ins_done, fits;
	logic [CNT_BITS-1:0]   need_sum;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign best_xor  = best_q;
	assign overflow  = full_q;
	assign key_bit   = chain[VALUE_BITS-1];
	assign prefix_nx = prefix_q ^ value;
	assign nf_lo     = nf_q[NODE_BITS-1:0];
	assign nf_inc    = nf_lo + NODE_BITS'(1);

	// key rotator cells
	for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
		mxt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (ch_load),
			.load_bit (chain_in[i]),
			.rot      (ch_rot),
			.shift_in (chain[(i + VALUE_BITS - 1) % VALUE_BITS]),
			.bit_q    (chain[i])
		);
	end

	// node memory
	mxt_ram #(.WIDTH(ENT_BITS), .DEPTH(NODE_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cur_q),
		.rdata (rdata)
	);

	// walk decisions
	always_comb begin
		other    = key_bit ? rdata[NODE_BITS-1:0] : rdata[ENT_BITS-1:NODE_BITS];
		same     = key_bit ? rdata[ENT_BITS-1:NODE_BITS] : rdata[NODE_BITS-1:0];
		nx       = same;
		gain_nx  = gain_q;
		if (other != '0) begin
			gain_nx = gain_q | ({{(VALUE_BITS-1){1'b0}}, 1'b1} << lvl_q);
		end
		q_end    = (other == '0 && same == '0) || (lvl_q == '0);
		need_sum = CNT_BITS'(nf_q) + CNT_BITS'(lvl_q) + CNT_BITS'(1);
		fits     = need_sum <= CNT_BITS'(NODE_COUNT);
		ins_done = 1'b0;
		if (state_q == S_IEV) begin
			ins_done = (nx != '0) ? (lvl_q == '0) : !fits;
		end else if (state_q == S_ALLOC) begin
			ins_done = (lvl_q == '0);
		end
	end

	// memory writes
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = '0;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = '0;
			end
			S_LINK: begin
				we    = 1'b1;
				wdata = key_bit ? {nf_lo, ent_q[NODE_BITS-1:0]}
				                : {ent_q[ENT_BITS-1:NODE_BITS], nf_lo};
			end
			S_ALLOC: begin
				we    = 1'b1;
				waddr = nf_lo;
				if (lvl_q != '0) begin
					wdata = key_bit ? {nf_inc, {NODE_BITS{1'b0}}}
					                : {{NODE_BITS{1'b0}}, nf_inc};
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// key rotator control: hold the level bit through the link write
	always_comb begin
		ch_load  = 1'b0;
		ch_rot   = 1'b0;
		chain_in = prefix_q;
		priority if (accept) begin
			ch_load  = 1'b1;
			chain_in = prefix_nx;
		end else if (state_q == S_CLR) begin
			ch_load  = 1'b1;
			chain_in = '0;
		end else if (state_q == S_QEV && q_end) begin
			ch_load = 1'b1;
		end else if (ins_done && init_q) begin
			ch_load = 1'b1;
		end else if (state_q == S_QEV || (state_q == S_IEV && nx != '0)
		             || state_q == S_LINK || state_q == S_ALLOC) begin
			ch_rot = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			prefix_q <= '0;
			best_q   <= '0;
			gain_q   <= '0;
			full_q   <= 1'b0;
			init_q   <= 1'b1;
			item_q   <= 1'b0;
			done_q   <= 1'b0;
			cur_q    <= '0;
			nf_q     <= '0;
			lvl_q    <= '0;
			ent_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= 1'b1;
						cur_q  <= '0;
						lvl_q  <= LVL_BITS'(VALUE_BITS - 1);
						gain_q <= '0;
						if (start_new) begin
							prefix_q <= value;
							best_q   <= '0;
							full_q   <= 1'b0;
							init_q   <= 1'b1;
							state_q  <= S_CLR;
						end else begin
							prefix_q <= prefix_nx;
							state_q  <= S_QRD;
						end
					end
				end
				S_CLR: begin
					nf_q    <= (NODE_BITS + 1)'(1);
					cur_q   <= '0;
					lvl_q   <= LVL_BITS'(VALUE_BITS - 1);
					state_q <= S_IRD;
				end
				S_QRD: begin
					state_q <= S_QEV;
				end
				S_QEV: begin
					gain_q <= gain_nx;
					if (q_end) begin
						if (gain_nx > best_q) begin
							best_q <= gain_nx;
						end
						cur_q <= '0;
						lvl_q <= LVL_BITS'(VALUE_BITS - 1);
						if (full_q) begin
							done_q  <= 1'b1;
							item_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_IRD;
						end
					end else begin
						cur_q   <= (other != '0) ? other : same;
						lvl_q   <= lvl_q - LVL_BITS'(1);
						state_q <= S_QRD;
					end
				end
				S_IRD: begin
					state_q <= S_IEV;
				end
				S_IEV: begin
					if (nx != '0) begin
						cur_q <= nx;
						if (lvl_q != '0) begin
							lvl_q   <= lvl_q - LVL_BITS'(1);
							state_q <= S_IRD;
						end
					end else if (!fits) begin
						full_q <= 1'b1;
					end else begin
						ent_q   <= rdata;
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_ALLOC;
				end
				S_ALLOC: begin
					nf_q <= nf_q + (NODE_BITS + 1)'(1);
					if (lvl_q != '0) begin
						lvl_q <= lvl_q - LVL_BITS'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// finish an insert walk
			if (ins_done) begin
				if (init_q) begin
					init_q <= 1'b0;
					if (item_q) begin
						cur_q   <= '0;
						lvl_q   <= LVL_BITS'(VALUE_BITS - 1);
						gain_q  <= '0;
						state_q <= S_QRD;
					end else begin
						state_q <= S_IDLE;
					end
				end else begin
					done_q  <= 1'b1;
					item_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			end
		end
	end
endmodule

>>> rtl/mxt_checker.sv
// ----------------------------------------------------------------------------
// mxt_checker
// Port-level checks on the command handshake of the trie block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_xor_subarray_trie_defines.svh"
module mxt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [mxt_pkg::VALUE_BITS-1:0] value,
	input logic                           start_new,
	input logic                           done,
	input logic [mxt_pkg::VALUE_BITS-1:0] best_xor,
	input logic                           overflow
);
	import mxt_pkg::*;

	// an accepted word keeps the block busy
	`MXT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// a result is shown only once the block is free
	`MXT_ASSERT_SAME(a_done_idle, done, !busy)
	// a result strobe lasts one cycle
	`MXT_ASSERT_NEXT(a_done_single, done, !done)
	// a fresh sequence clears overflow
	`MXT_ASSERT_NEXT(a_new_clears, start && !busy && start_new, !overflow)
endmodule

bind max_xor_subarray_trie mxt_checker u_mxt_checker (.*);
